// File: rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/ltps_pkg.sv
// Types and constants shared by the LED test pattern sequencer modules.
package ltps_pkg;

   localparam int LedWidth = 8;

   // Pattern codes, in the order the sequence runs them.
   localparam logic [2:0] PatAllOn     = 3'd0;
   localparam logic [2:0] PatAllOff    = 3'd1;
   localparam logic [2:0] PatWalkOne   = 3'd2;
   localparam logic [2:0] PatWalkZero  = 3'd3;
   localparam logic [2:0] PatCount     = 3'd4;
   localparam logic [2:0] PatAlternate = 3'd5;

   // Steps per pattern run.
   localparam logic [8:0] StepsSingle = 9'd1;
   localparam logic [8:0] StepsWalk   = 9'(2 * LedWidth - 1);
   localparam logic [8:0] StepsCount  = 9'd256;
   localparam logic [8:0] StepsAlt    = 9'd8;

   localparam logic [LedWidth-1:0] LedAllOn  = 8'hFF;
   localparam logic [LedWidth-1:0] LedAllOff = 8'h00;
   localparam logic [LedWidth-1:0] LedAltEven = 8'h55;
   localparam logic [LedWidth-1:0] LedAltOdd  = 8'hAA;

   // Configuration register indexes.
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CsrStepTicks   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrPauseTicks  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrRepeatCount = 2'd2;

   localparam logic [15:0] StepTicksReset   = 16'd100;
   localparam logic [15:0] PauseTicksReset  = 16'd500;
   localparam logic [7:0]  RepeatCountReset = 8'd1;

   typedef struct packed {
      logic [15:0] step_ticks;
      logic [15:0] pause_ticks;
      logic [7:0]  repeat_count;
   } cfg_type;

   typedef struct packed {
      logic [2:0]          pattern_index;
      logic [8:0]          step_index;
      logic [7:0]          repeat_index;
      logic [17:0]         hold_counter;
      logic                pause_flag;
      logic [LedWidth-1:0] led_register;
   } seq_state_type;

   localparam seq_state_type SeqStart = '{
      pattern_index: 3'd0,
      step_index:    9'd0,
      repeat_index:  8'd0,
      hold_counter:  18'd0,
      pause_flag:    1'b0,
      led_register:  LedAllOn
   };

endpackage

// File: rtl/ltps_next_state.sv
// Next-state logic of the LED test pattern sequencer for one tick word.
module ltps_next_state (
   input  ltps_pkg::seq_state_type cur_state,
   input  ltps_pkg::cfg_type       cfg,
   input  logic                    tick,
   input  logic                    restart,
   output ltps_pkg::seq_state_type nxt_state,
   output logic                    wrap
);

   function automatic logic [8:0] steps_of(input logic [2:0] p);
      logic [8:0] n;
      case (p)
         ltps_pkg::PatAllOn, ltps_pkg::PatAllOff:    n = ltps_pkg::StepsSingle;
         ltps_pkg::PatWalkOne, ltps_pkg::PatWalkZero: n = ltps_pkg::StepsWalk;
         ltps_pkg::PatCount:                           n = ltps_pkg::StepsCount;
         ltps_pkg::PatAlternate:                       n = ltps_pkg::StepsAlt;
         default:                                      n = ltps_pkg::StepsSingle;
      endcase
      return n;
   endfunction

   function automatic logic [ltps_pkg::LedWidth-1:0] led_of(input logic [2:0] p,
                                                           input logic [8:0] s);
      logic [3:0]                      mirror;
      logic [2:0]                      pos;
      logic [ltps_pkg::LedWidth-1:0] one;
      logic [ltps_pkg::LedWidth-1:0] v;
      // Walk goes up to the top LED, then back down.
      mirror = 4'd14 - s[3:0];
      pos    = (s < 9'd8) ? s[2:0] : mirror[2:0];
      one    = ltps_pkg::LedWidth'(1) << pos;
      case (p)
         ltps_pkg::PatAllOn:     v = ltps_pkg::LedAllOn;
         ltps_pkg::PatAllOff:    v = ltps_pkg::LedAllOff;
         ltps_pkg::PatWalkOne:   v = one;
         ltps_pkg::PatWalkZero:  v = ~one;
         ltps_pkg::PatCount:     v = s[7:0];
         ltps_pkg::PatAlternate: v = s[0] ? ltps_pkg::LedAltOdd : ltps_pkg::LedAltEven;
         default:                v = ltps_pkg::LedAllOff;
      endcase
      return v;
   endfunction

   logic [17:0] duration;
   logic [17:0] duration_raw;
   logic [17:0] hold_inc;
   logic [8:0]  step_inc;
   logic [7:0]  repeat_inc;
   logic [7:0]  repeat_limit;

   always_comb begin
      if (cur_state.pause_flag) begin
         duration_raw = {2'b00, cfg.pause_ticks};
      end else begin
         case (cur_state.pattern_index)
            ltps_pkg::PatAllOn, ltps_pkg::PatAllOff: duration_raw = {cfg.step_ticks, 2'b00};
            ltps_pkg::PatCount: duration_raw = {4'b0000, cfg.step_ticks[15:2]};
            default:            duration_raw = {2'b00, cfg.step_ticks};
         endcase
      end
      // A duration of zero still lasts one tick.
      duration = (duration_raw == 18'd0) ? 18'd1 : duration_raw;
   end

   assign hold_inc     = cur_state.hold_counter + 18'd1;
   assign step_inc     = cur_state.step_index + 9'd1;
   assign repeat_inc   = cur_state.repeat_index + 8'd1;
   assign repeat_limit = (cfg.repeat_count == 8'd0) ? 8'd1 : cfg.repeat_count;

   always_comb begin
      nxt_state = cur_state;
      wrap      = 1'b0;
      if (restart) begin
         nxt_state = ltps_pkg::SeqStart;
      end else if (tick) begin
         if (hold_inc >= duration) begin
            nxt_state.hold_counter = 18'd0;
            if (cur_state.pause_flag) begin
               nxt_state.pause_flag   = 1'b0;
               nxt_state.step_index   = 9'd0;
               nxt_state.repeat_index = 8'd0;
               if (cur_state.pattern_index >= ltps_pkg::PatAlternate) begin
                  nxt_state.pattern_index = ltps_pkg::PatAllOn;
                  wrap = 1'b1;
               end else begin
                  nxt_state.pattern_index = cur_state.pattern_index + 3'd1;
               end
            end else if (step_inc >= steps_of(cur_state.pattern_index)) begin
               nxt_state.step_index = 9'd0;
               if (repeat_inc >= repeat_limit || repeat_inc == 8'd0) begin
                  nxt_state.repeat_index = 8'd0;
                  nxt_state.pause_flag   = 1'b1;
               end else begin
                  nxt_state.repeat_index = repeat_inc;
               end
            end else begin
               nxt_state.step_index = step_inc;
            end
            nxt_state.led_register = nxt_state.pause_flag ? ltps_pkg::LedAllOff :
                                     led_of(nxt_state.pattern_index, nxt_state.step_index);
         end else begin
            nxt_state.hold_counter = hold_inc;
         end
      end
   end

endmodule

// File: rtl/led_test_pattern_sequencer.sv
// Top level of the tick-driven eight-LED test pattern sequencer.
// Latency: the result word for a request word is valid in the cycle after it is accepted.
// Throughput: one request word per clock; the sequencer state doubles as the result
// register, so a word is taken whenever the result slot is empty or being drained.
// Reset (synchronous, active high) loads the first pattern (all LEDs on), restores the
// register defaults (100, 500, 1) and empties the result slot.
`include "assert_macros.svh"

module led_test_pattern_sequencer (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel: one tick/restart word per accepted handshake.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_tick,
   input  logic                                   req_restart,
   // Result channel: one LED status word per request word.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ltps_pkg::LedWidth-1:0]          rsp_led_value,
   output logic [2:0]                             rsp_pattern_number,
   output logic                                   rsp_in_pause,
   output logic                                   rsp_sequence_wrap,
   // Configuration write channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ltps_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [15:0]                            csr_data
);

   ltps_pkg::cfg_type       cfg_ff;
   ltps_pkg::cfg_type       cfg_in;
   ltps_pkg::seq_state_type state_ff;
   ltps_pkg::seq_state_type state_in;
   ltps_pkg::seq_state_type state_calc;
   logic                    wrap_ff;
   logic                    wrap_in;
   logic                    wrap_calc;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    req_accept;

   // Registers are always writable; the user must write only while idle, the block does not enforce it.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ltps_pkg::CsrStepTicks:   cfg_in.step_ticks   = csr_data;
            ltps_pkg::CsrPauseTicks:  cfg_in.pause_ticks  = csr_data;
            ltps_pkg::CsrRepeatCount: cfg_in.repeat_count = csr_data[7:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   // The sequencer state is also the result register, so a new word may enter
   // whenever the previous result is gone or leaves in this same cycle.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   ltps_next_state u_next_state (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .tick      (req_tick),
      .restart   (req_restart),
      .nxt_state (state_calc),
      .wrap      (wrap_calc)
   );

   // State moves only when a word is accepted; a held result keeps its values.
   assign state_in     = req_accept ? state_calc : state_ff;
   assign wrap_in      = req_accept ? wrap_calc : wrap_ff;
   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{step_ticks:   ltps_pkg::StepTicksReset,
                           pause_ticks:  ltps_pkg::PauseTicksReset,
                           repeat_count: ltps_pkg::RepeatCountReset};
         state_ff     <= ltps_pkg::SeqStart;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_led_value      = state_ff.led_register;
   assign rsp_pattern_number = state_ff.pattern_index;
   assign rsp_in_pause       = state_ff.pause_flag;
   assign rsp_sequence_wrap  = wrap_ff;

   // The pattern counter must never run past the last pattern.
   `ASSERT_CLK(a_pattern_range, state_ff.pattern_index <= ltps_pkg::PatAlternate,
      "pattern index out of range")
   // During a pause every LED is dark.
   `ASSERT_CLK(a_pause_dark,
      state_ff.pause_flag |-> state_ff.led_register == ltps_pkg::LedAllOff,
      "LEDs lit during pause")
   // A wrap starts the first pattern outside any pause.
   `ASSERT_CLK(a_wrap_start, (rsp_valid_ff && wrap_ff) |->
      (state_ff.pattern_index == ltps_pkg::PatAllOn && !state_ff.pause_flag),
      "wrap without a fresh first pattern")
   // An accepted restart word shows the start of the sequence in the next result.
   `ASSERT_CLK(a_restart, (req_accept && req_restart) |=>
      (rsp_valid_ff && !wrap_ff && state_ff.led_register == ltps_pkg::LedAllOn &&
       state_ff.pattern_index == ltps_pkg::PatAllOn),
      "restart not applied")
   // Coming out of reset the result slot is empty.
   `ASSERT_CLK_ALWAYS(a_reset_empty, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

// File: dv/tb_led_test_pattern_sequencer.sv
// Self-checking testbench for the tick-driven eight-LED test pattern sequencer.
module tb_led_test_pattern_sequencer;

   // The one register index that the block does not define. A write to it must change nothing.
   localparam logic [ltps_pkg::CsrIndexWidth-1:0] CsrSpare = 2'd3;

   // One result word as the block reports it.
   typedef struct packed {
      logic [ltps_pkg::LedWidth-1:0] led_value;
      logic [2:0]                    pattern_number;
      logic                          in_pause;
      logic                          sequence_wrap;
   } led_word_type;

   localparam led_word_type NoWord = '0;

   // A directed row either sends one request word or writes one register.
   typedef enum logic {RowWord, RowCsr} row_kind_type;

   typedef struct packed {
      row_kind_type                       kind;
      logic                               tick;
      logic                               restart;
      logic                               typed;
      led_word_type                       word;
      logic [ltps_pkg::CsrIndexWidth-1:0] csr_sel;
      logic [15:0]                        csr_value;
   } plan_row_type;

   localparam logic [ltps_pkg::LedWidth-1:0] On  = ltps_pkg::LedAllOn;
   localparam logic [ltps_pkg::LedWidth-1:0] Off = ltps_pkg::LedAllOff;
   localparam logic [2:0] P0 = ltps_pkg::PatAllOn;
   localparam logic [2:0] P1 = ltps_pkg::PatAllOff;
   localparam logic [2:0] P2 = ltps_pkg::PatWalkOne;
   localparam logic [ltps_pkg::CsrIndexWidth-1:0] CStep = ltps_pkg::CsrStepTicks;
   localparam logic [ltps_pkg::CsrIndexWidth-1:0] CPause = ltps_pkg::CsrPauseTicks;
   localparam logic [ltps_pkg::CsrIndexWidth-1:0] CRep = ltps_pkg::CsrRepeatCount;

   // The directed plan. Rows with typed set carry a result that can be read off directly;
   // every other row is checked against the sequencer model below.
   localparam plan_row_type PLAN [20] = '{
      // Right after reset, with the register defaults, nothing moves for a while.
      '{RowWord, 1'b0, 1'b0, 1'b1, '{On, P0, 1'b0, 1'b0}, CStep, 16'd0},
      '{RowWord, 1'b1, 1'b0, 1'b1, '{On, P0, 1'b0, 1'b0}, CStep, 16'd0},
      // Restart together with a tick: the restart wins.
      '{RowWord, 1'b1, 1'b1, 1'b1, '{On, P0, 1'b0, 1'b0}, CStep, 16'd0},
      '{RowWord, 1'b0, 1'b1, 1'b1, '{On, P0, 1'b0, 1'b0}, CStep, 16'd0},
      // Zero step, zero pause and zero repeat count: each duration lasts one tick, one run.
      '{RowCsr,  1'b0, 1'b0, 1'b0, NoWord, CStep,  16'd0},
      '{RowCsr,  1'b0, 1'b0, 1'b0, NoWord, CPause, 16'd0},
      '{RowCsr,  1'b0, 1'b0, 1'b0, NoWord, CRep,   16'd0},
      '{RowWord, 1'b1, 1'b0, 1'b1, '{Off, P0, 1'b1, 1'b0}, CStep, 16'd0},
      '{RowWord, 1'b1, 1'b0, 1'b1, '{Off, P1, 1'b0, 1'b0}, CStep, 16'd0},
      '{RowWord, 1'b1, 1'b0, 1'b1, '{Off, P1, 1'b1, 1'b0}, CStep, 16'd0},
      '{RowWord, 1'b1, 1'b0, 1'b1, '{8'h01, P2, 1'b0, 1'b0}, CStep, 16'd0},
      '{RowWord, 1'b1, 1'b0, 1'b0, NoWord, CStep, 16'd0},
      '{RowWord, 1'b0, 1'b0, 1'b0, NoWord, CStep, 16'd0},
      // Largest values; the repeat count write carries set upper data bits.
      '{RowCsr,  1'b0, 1'b0, 1'b0, NoWord, CStep,  16'hFFFF},
      '{RowCsr,  1'b0, 1'b0, 1'b0, NoWord, CPause, 16'hFFFF},
      '{RowCsr,  1'b0, 1'b0, 1'b0, NoWord, CRep,   16'hFFFF},
      '{RowWord, 1'b1, 1'b0, 1'b0, NoWord, CStep, 16'd0},
      '{RowWord, 1'b1, 1'b1, 1'b1, '{On, P0, 1'b0, 1'b0}, CStep, 16'd0},
      '{RowCsr,  1'b0, 1'b0, 1'b0, NoWord, CsrSpare, 16'hFFFF},
      '{RowWord, 1'b1, 1'b0, 1'b0, NoWord, CStep, 16'd0}
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_tick = 1'b0;
   logic                               req_restart = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [ltps_pkg::LedWidth-1:0]      rsp_led_value;
   logic [2:0]                         rsp_pattern_number;
   logic                               rsp_in_pause;
   logic                               rsp_sequence_wrap;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [ltps_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [15:0]                        csr_data = '0;

   // A typed expectation travels with the request word it belongs to.
   logic         word_typed = 1'b0;
   led_word_type word_typed_value = NoWord;

   // Model state: register copies, sequencer state and the words still owed by the block.
   ltps_pkg::cfg_type       model_cfg;
   ltps_pkg::seq_state_type model_seq;
   led_word_type            led_words_due [$];
   int unsigned             mismatch_count = 0;

   // Receiver stall shaping. When calm is set, the result side never stalls.
   bit            calm = 1'b0;
   int unsigned   stall_left = 0;

   led_test_pattern_sequencer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_tick           (req_tick),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_led_value      (rsp_led_value),
      .rsp_pattern_number (rsp_pattern_number),
      .rsp_in_pause       (rsp_in_pause),
      .rsp_sequence_wrap  (rsp_sequence_wrap),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   // Number of steps in one run of a pattern. The unused codes count as one step.
   function automatic int unsigned run_steps(logic [2:0] pat);
      case (pat)
         ltps_pkg::PatAllOn, ltps_pkg::PatAllOff:     return 32'(ltps_pkg::StepsSingle);
         ltps_pkg::PatWalkOne, ltps_pkg::PatWalkZero: return 32'(ltps_pkg::StepsWalk);
         ltps_pkg::PatCount:                          return 32'(ltps_pkg::StepsCount);
         ltps_pkg::PatAlternate:                      return 32'(ltps_pkg::StepsAlt);
         default:                                     return 32'(ltps_pkg::StepsSingle);
      endcase
   endfunction

   // Ticks that the current step or pause lasts. A zero duration still lasts one tick.
   function automatic int unsigned hold_limit();
      int unsigned d;
      if (model_seq.pause_flag) begin
         d = 32'(model_cfg.pause_ticks);
      end else begin
         case (model_seq.pattern_index)
            ltps_pkg::PatAllOn, ltps_pkg::PatAllOff: d = 32'(model_cfg.step_ticks) * 4;
            ltps_pkg::PatCount:                      d = 32'(model_cfg.step_ticks) / 4;
            default:                                 d = 32'(model_cfg.step_ticks);
         endcase
      end
      return (d == 0) ? 1 : d;
   endfunction

   // LED byte shown for a given pattern and step.
   function automatic logic [ltps_pkg::LedWidth-1:0] pattern_leds(logic [2:0] pat,
                                                                  logic [8:0] step);
      int unsigned                   pos;
      logic [ltps_pkg::LedWidth-1:0] walk;
      // The walk climbs from LED 0 to LED 7 and then comes back down to LED 0.
      pos  = (step < ltps_pkg::LedWidth) ? 32'(step) :
             2 * ltps_pkg::LedWidth - 2 - 32'(step);
      walk = ltps_pkg::LedWidth'(1 << (pos & 7));
      case (pat)
         ltps_pkg::PatAllOn:     return ltps_pkg::LedAllOn;
         ltps_pkg::PatAllOff:    return ltps_pkg::LedAllOff;
         ltps_pkg::PatWalkOne:   return walk;
         ltps_pkg::PatWalkZero:  return ~walk;
         ltps_pkg::PatCount:     return step[7:0];
         ltps_pkg::PatAlternate: return step[0] ? ltps_pkg::LedAltOdd : ltps_pkg::LedAltEven;
         default:                return ltps_pkg::LedAllOff;
      endcase
   endfunction

   // Moves the sequencer model by one request word and returns the word the block owes.
   function automatic led_word_type advance_sequencer(logic tick, logic restart);
      led_word_type w;
      int unsigned  limit;
      int unsigned  runs;
      w.sequence_wrap = 1'b0;
      if (restart) begin
         model_seq = ltps_pkg::SeqStart;
      end else if (tick) begin
         limit = hold_limit();
         model_seq.hold_counter = model_seq.hold_counter + 18'd1;
         if (model_seq.hold_counter >= limit) begin
            model_seq.hold_counter = '0;
            if (model_seq.pause_flag) begin
               // The pause is over: on to the next pattern, or back to the first one.
               model_seq.pause_flag   = 1'b0;
               model_seq.step_index   = '0;
               model_seq.repeat_index = '0;
               if (model_seq.pattern_index >= ltps_pkg::PatAlternate) begin
                  model_seq.pattern_index = ltps_pkg::PatAllOn;
                  w.sequence_wrap = 1'b1;
               end else begin
                  model_seq.pattern_index = model_seq.pattern_index + 3'd1;
               end
            end else begin
               runs = (model_cfg.repeat_count == 0) ? 1 : 32'(model_cfg.repeat_count);
               model_seq.step_index = model_seq.step_index + 9'd1;
               if (model_seq.step_index >= run_steps(model_seq.pattern_index)) begin
                  model_seq.step_index   = '0;
                  model_seq.repeat_index = model_seq.repeat_index + 8'd1;
                  if (model_seq.repeat_index >= runs || model_seq.repeat_index == 0) begin
                     model_seq.repeat_index = '0;
                     model_seq.pause_flag   = 1'b1;
                  end
               end
            end
            model_seq.led_register = model_seq.pause_flag ? ltps_pkg::LedAllOff :
               pattern_leds(model_seq.pattern_index, model_seq.step_index);
         end
      end
      w.led_value      = model_seq.led_register;
      w.pattern_number = model_seq.pattern_index;
      w.in_pause       = model_seq.pause_flag;
      return w;
   endfunction

   // Gap length for either side: mostly none, sometimes a short one, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      else if (roll < 95) return $urandom_range(1, 3);
      else return $urandom_range(10, 40);
   endfunction

   // Everything is sampled at the rising edge, before the block's own updates land.
   // The result check comes first: a word accepted at this edge can only be answered later.
   always @(posedge clock) begin
      led_word_type got;
      led_word_type want;
      if (reset) begin
         model_cfg.step_ticks   = ltps_pkg::StepTicksReset;
         model_cfg.pause_ticks  = ltps_pkg::PauseTicksReset;
         model_cfg.repeat_count = ltps_pkg::RepeatCountReset;
         model_seq = ltps_pkg::SeqStart;
         led_words_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_led_value, rsp_pattern_number, rsp_in_pause, rsp_sequence_wrap};
            if (led_words_due.size() == 0) begin
               $error("result word arrived with no word expected");
               mismatch_count++;
            end else begin
               want = led_words_due.pop_front();
               if (got.led_value !== want.led_value) begin
                  $error("led_value: expected %02h, got %02h", want.led_value, got.led_value);
                  mismatch_count++;
               end
               if (got.pattern_number !== want.pattern_number) begin
                  $error("pattern_number: expected %0d, got %0d",
                         want.pattern_number, got.pattern_number);
                  mismatch_count++;
               end
               if (got.in_pause !== want.in_pause) begin
                  $error("in_pause: expected %0b, got %0b", want.in_pause, got.in_pause);
                  mismatch_count++;
               end
               if (got.sequence_wrap !== want.sequence_wrap) begin
                  $error("sequence_wrap: expected %0b, got %0b",
                         want.sequence_wrap, got.sequence_wrap);
                  mismatch_count++;
               end
            end
         end
         // Register writes mirror what the block keeps: 16 bits, or 8 for the repeat count.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ltps_pkg::CsrStepTicks:   model_cfg.step_ticks   = csr_data;
               ltps_pkg::CsrPauseTicks:  model_cfg.pause_ticks  = csr_data;
               ltps_pkg::CsrRepeatCount: model_cfg.repeat_count = csr_data[7:0];
               default:                  ;
            endcase
         end
         // The model always advances; a typed row replaces its answer with the typed one.
         if (req_valid && !req_stall) begin
            if (word_typed) begin
               void'(advance_sequencer(req_tick, req_restart));
               led_words_due.push_back(word_typed_value);
            end else begin
               led_words_due.push_back(advance_sequencer(req_tick, req_restart));
            end
         end
      end
   end

   // The result side stalls for random stretches that never run back to back.
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
      end
   end

   // Presents one request word and holds it until the block takes it.
   task automatic send_word(input logic tick, input logic restart,
                            input logic typed, input led_word_type typed_value);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_tick         <= tick;
      req_restart      <= restart;
      word_typed       <= typed;
      word_typed_value <= typed_value;
      do @(posedge clock); while (req_stall);
   endtask

   // Keeps the request side quiet for the given number of cycles.
   task automatic pause_sender(input int unsigned cycles);
      if (cycles != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Stops sending and waits until every owed word has come back, plus the block's latency.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (led_words_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // One register write; only ever issued while the block is idle.
   task automatic write_csr(input logic [ltps_pkg::CsrIndexWidth-1:0] sel,
                            input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned sent;
      int unsigned roll;
      int unsigned burst;
      logic [15:0] step_val;
      logic [15:0] pause_val;
      logic [15:0] repeat_val;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: reset values, restart priority, zero and largest register values, spare index write.
      for (int r = 0; r < $size(PLAN); r++) begin
         if (PLAN[r].kind == RowCsr) begin
            wait_idle();
            write_csr(PLAN[r].csr_sel, PLAN[r].csr_value);
         end else begin
            send_word(PLAN[r].tick, PLAN[r].restart, PLAN[r].typed, PLAN[r].word);
         end
      end

      // Random part, in phases. Each phase starts from an idle block with fresh register
      // values. The sequencer state carries over, so a new duration can land on a step that
      // has already run past it. Small durations dominate so that the whole sequence,
      // wrap included, is walked several times; restarts are rare for the same reason.
      sent = 0;
      while (sent < 1500) begin
         wait_idle();
         calm = ($urandom_range(0, 3) == 0);

         roll = $urandom_range(0, 9);
         if (roll < 7) step_val = 16'($urandom_range(0, 4));
         else if (roll == 7) step_val = 16'hFFFF;
         else if (roll == 8) step_val = 16'($urandom);
         else step_val = 16'd1;
         write_csr(ltps_pkg::CsrStepTicks, step_val);

         roll = $urandom_range(0, 9);
         if (roll < 7) pause_val = 16'($urandom_range(0, 4));
         else if (roll == 7) pause_val = 16'hFFFF;
         else if (roll == 8) pause_val = 16'($urandom);
         else pause_val = 16'd0;
         write_csr(ltps_pkg::CsrPauseTicks, pause_val);

         // Random 16-bit data also exercises the upper bits the repeat count drops.
         roll = $urandom_range(0, 19);
         if (roll < 12) repeat_val = 16'd1;
         else if (roll < 15) repeat_val = 16'd0;
         else if (roll < 18) repeat_val = 16'($urandom_range(2, 3));
         else if (roll == 18) repeat_val = 16'd255;
         else repeat_val = 16'($urandom);
         write_csr(ltps_pkg::CsrRepeatCount, repeat_val);

         if ($urandom_range(0, 7) == 0) write_csr(CsrSpare, 16'($urandom));

         // Long durations only hold the LEDs, so those phases stay short.
         burst = (step_val > 64 || pause_val > 64) ? 25 : $urandom_range(60, 200);
         for (int i = 0; i < burst; i++) begin
            if (!calm) pause_sender(pick_gap());
            // Now and then the sender holds off until every owed word is back.
            if ($urandom_range(0, 99) == 0) wait_idle();
            send_word($urandom_range(0, 9) != 0, $urandom_range(0, 299) == 0, 1'b0, NoWord);
            sent++;
         end
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
